[hw/rtl/crc_framed_command_encoder_assert.svh]
// Assertion macros shared by the CRC framed command encoder RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef CRC_FRAMED_COMMAND_ENCODER_ASSERT_SVH
`define CRC_FRAMED_COMMAND_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define CRCE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define CRCE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CRCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRCE_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/crce_pkg.sv]
// Shared types, constants and CRC helper functions for the encoder.
// No dependencies; imported by every RTL file but the assertion header.
package crce_pkg;

	localparam int unsigned CRC_W          = 32;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned TRAILER_BYTES  = 4;
	localparam int unsigned CFG_IDX_W      = 8;
	localparam int unsigned FIFO_DEPTH_DEF = 4;

	localparam logic [CRC_W-1:0] CRC_POLY_RST = 32'h04C11DB7;
	localparam logic [CRC_W-1:0] CRC_INIT_RST = 32'hFFFFFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT = 8'd1;

	typedef logic [CRC_W-1:0] crc_word_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// column j holds the 32-shift image of bit j of the CRC word
	typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

	// front to back queue entry
	typedef struct packed {
		byte_t     data_byte;
		logic      is_last;
		crc_word_t crc;
	} crce_entry_t;

	// status from the matrix builder to the front
	typedef struct packed {
		logic     busy;
		crc_mat_t cols;
	} crce_mat_t;

	// one MSB-first shift step with the polynomial
	function automatic crc_word_t crc_shift(input crc_word_t v, input crc_word_t poly);
		crc_word_t r;
		r = {v[CRC_W-2:0], 1'b0};
		if (v[CRC_W-1]) begin
			r = r ^ poly;
		end
		return r;
	endfunction

	// 32 shifts are linear in the word: XOR the columns selected by its bits
	function automatic crc_word_t crc_fold(input crc_mat_t cols, input crc_word_t x);
		crc_word_t acc;
		acc = '0;
		for (int j = 0; j < CRC_W; j++) begin
			if (x[j]) begin
				acc = acc ^ cols[j];
			end
		end
		return acc;
	endfunction

endpackage

[hw/rtl/crce_ifs.sv]
// Valid/ready channel interfaces: command bytes in, frame bytes out, config writes.
// Depends on crce_pkg for field widths.
interface crce_cmd_if import crce_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  is_header;
	logic  is_last;

	modport source (output valid, output data_byte, output is_header, output is_last,
		input ready);
	modport sink (input valid, input data_byte, input is_header, input is_last,
		output ready);
endinterface

interface crce_tx_if import crce_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  frame_end;

	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

interface crce_cfg_if import crce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	crc_word_t            data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/crce_matrix.sv]
// Builds the 32x32 fold matrix from the polynomial, one column per cycle.
// Depends on crce_pkg.
module crce_matrix import crce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      poly_we,
	input  crc_word_t poly_wdata,
	output crce_mat_t mat
);

	localparam int unsigned IDX_W = $clog2(CRC_W);

	crc_word_t  poly_q;
	crc_word_t  cur_q;
	logic [IDX_W-1:0] idx_q;
	logic       busy_q;
	crc_mat_t   cols_q;

	// sweep: col0 = poly, col(j+1) = one shift of col(j)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= CRC_POLY_RST;
			cur_q  <= CRC_POLY_RST;
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (poly_we) begin
			poly_q <= poly_wdata;
			cur_q  <= poly_wdata;
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cur_q <= crc_shift(cur_q, poly_q);
			idx_q <= idx_q + 1'b1;
			if (idx_q == IDX_W'(CRC_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// column storage, payload only
	always_ff @(posedge clk) begin
		if (busy_q && !poly_we) begin
			cols_q[idx_q] <= cur_q;
		end
	end

	assign mat.busy = busy_q;
	assign mat.cols = cols_q;

endmodule

[hw/rtl/crce_front.sv]
// Front end: takes command bytes, tracks the CRC register, pushes queue entries.
// Depends on crce_pkg and the channel interfaces.
module crce_front import crce_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	crce_cmd_if.sink        cmd,
	input  crce_mat_t       mat,
	input  logic            init_we,
	input  crc_word_t       init_wdata,
	input  logic            q_full,
	output logic            q_push,
	output crce_entry_t     q_wdata
);

	crc_word_t init_q;
	crc_word_t crc_q;
	crc_word_t crc_next;

	// hold off while the matrix is rebuilt or the queue is full
	assign cmd.ready = !mat.busy && !q_full;
	assign q_push    = cmd.valid && cmd.ready;

	// header reloads, body byte folds in at the low bits
	always_comb begin
		if (cmd.is_header) begin
			crc_next = init_q;
		end else begin
			crc_next = crc_fold(mat.cols, crc_q ^ {{(CRC_W-BYTE_W){1'b0}}, cmd.data_byte});
		end
	end

	assign q_wdata.data_byte = cmd.data_byte;
	assign q_wdata.is_last   = cmd.is_last;
	assign q_wdata.crc       = crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= CRC_INIT_RST;
			crc_q  <= CRC_INIT_RST;
		end else begin
			if (init_we) begin
				init_q <= init_wdata;
			end
			if (q_push) begin
				crc_q <= crc_next;
			end
		end
	end

endmodule

[hw/rtl/crce_fifo.sv]
// Short queue between front and back ends, flop storage, show-ahead read.
// Depends on crce_pkg and the assertion macro header.
`include "crc_framed_command_encoder_assert.svh"

module crce_fifo import crce_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  crce_entry_t wdata,
	input  logic        pop,
	output crce_entry_t rdata,
	output logic        full,
	output logic        empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	crce_entry_t       mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CRCE_NEVER(a_no_push_full, clk, arst_n, push && full, "push into full queue")
	`CRCE_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "pop from empty queue")
	`CRCE_ASSERT(a_count_up, clk, arst_n, push && !pop |=> count_q == $past(count_q) + 1'b1, "fill count did not follow push")

endmodule

[hw/rtl/crce_back.sv]
// Back end: emits queued bytes and, after a last byte, the four CRC trailer bytes.
// Depends on crce_pkg, the channel interfaces and the assertion macro header.
`include "crc_framed_command_encoder_assert.svh"

module crce_back import crce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crce_entry_t q_rdata,
	input  logic        q_empty,
	output logic        q_pop,
	crce_tx_if.source   tx
);

	localparam int unsigned TCW = $clog2(TRAILER_BYTES + 1);

	logic           out_valid_q;
	byte_t          out_byte_q;
	logic           frame_end_q;
	crc_word_t      crc_q;
	logic [TCW-1:0] trl_cnt_q;
	logic           can_load;

	// output register frees up when empty or taken this cycle
	assign can_load = !out_valid_q || tx.ready;
	assign q_pop    = can_load && (trl_cnt_q == '0) && !q_empty;

	assign tx.valid     = out_valid_q;
	assign tx.out_byte  = out_byte_q;
	assign tx.frame_end = frame_end_q;

	// control: valid and trailer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			trl_cnt_q   <= '0;
		end else if (can_load) begin
			if (trl_cnt_q != '0) begin
				out_valid_q <= 1'b1;
				trl_cnt_q   <= trl_cnt_q - 1'b1;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				if (q_rdata.is_last) begin
					trl_cnt_q <= TCW'(TRAILER_BYTES);
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: frame byte, or trailer byte LSB first
	always_ff @(posedge clk) begin
		if (can_load) begin
			if (trl_cnt_q != '0) begin
				out_byte_q  <= crc_q[BYTE_W-1:0];
				frame_end_q <= (trl_cnt_q == TCW'(1));
				crc_q       <= crc_q >> BYTE_W;
			end else if (!q_empty) begin
				out_byte_q  <= q_rdata.data_byte;
				frame_end_q <= 1'b0;
				crc_q       <= q_rdata.crc;
			end
		end
	end

	`CRCE_NEVER(a_no_pop_in_trailer, clk, arst_n, q_pop && trl_cnt_q != '0, "pop during trailer")
	`CRCE_ASSERT(a_trailer_valid, clk, arst_n, trl_cnt_q != '0 |-> out_valid_q, "trailer pending without valid output")
	`CRCE_ASSERT(a_end_last, clk, arst_n, out_valid_q && frame_end_q |-> trl_cnt_q == '0, "frame end before trailer done")

endmodule

[hw/rtl/crc_framed_command_encoder.sv]
// CRC framed command encoder, top level.
// Channels: cmd (sink) takes one frame byte per item with is_header/is_last marks;
// tx (source) gives out_byte/frame_end items; cfg (sink) writes index 0 =
// polynomial, 1 = initial value, other indexes are ignored. cfg.ready is always high.
// Every byte is passed through; after a byte marked last four CRC bytes follow,
// least significant first, the fourth one with frame_end set.
// A taken cmd item goes to the queue, then to the output register that drives tx.
// Throughput: one item per cycle unless tx stalls, the matrix is being rebuilt or
// a trailer goes out. The CRC update is one XOR tree over a 32x32 fold matrix.
// After reset and after every polynomial write the matrix is rebuilt one
// column per cycle: cmd.ready stays low until all 32 columns are built.
// When tx stalls, the output register and a FIFO_DEPTH entry queue absorb items,
// then cmd.ready drops until room frees up. Reset clears the queue and
// loads the CRC register with all ones.
// Depends on crce_pkg, crce_ifs and the crce_* submodules.
module crc_framed_command_encoder import crce_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	crce_cmd_if.sink   cmd,
	crce_tx_if.source  tx,
	crce_cfg_if.sink   cfg
);

	logic        poly_we;
	logic        init_we;
	crce_mat_t   mat;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	crce_entry_t q_wdata;
	crce_entry_t q_rdata;

	// config register decode
	assign cfg.ready = 1'b1;
	assign poly_we   = cfg.valid && (cfg.index == REG_POLY);
	assign init_we   = cfg.valid && (cfg.index == REG_INIT);

	crce_matrix u_matrix (
		.clk        (clk),
		.arst_n     (arst_n),
		.poly_we    (poly_we),
		.poly_wdata (cfg.data),
		.mat        (mat)
	);

	crce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mat        (mat),
		.init_we    (init_we),
		.init_wdata (cfg.data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	crce_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	crce_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rdata (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.tx      (tx)
	);

endmodule

[verif/tb_crc_framed_command_encoder.sv]
// Self-checking testbench for crc_framed_command_encoder: frames in, bytes and CRC trailer out.
// Depends on crce_pkg and the crce_ifs channel interfaces; predicts results bit-serially.
module tb_crc_framed_command_encoder import crce_pkg::*; ();

	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 52;

	// indexes outside the register map, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

	typedef struct packed {
		byte_t out_byte;
		logic  frame_end;
	} tx_item_t;

	// CRC state, register copies and the queue of bytes the block owes on tx
	class crc_frame_predictor;
		crc_word_t poly;
		crc_word_t init_val;
		crc_word_t crc;
		tx_item_t  expected_bytes[$];
		int        mismatches;

		function new();
			poly       = CRC_POLY_RST;
			init_val   = CRC_INIT_RST;
			crc        = CRC_INIT_RST;
			mismatches = 0;
		endfunction

		function void apply_cfg(logic [CFG_IDX_W-1:0] idx, crc_word_t val);
			case (idx)
				REG_POLY: poly = val;
				REG_INIT: init_val = val;
				default: ;
			endcase
		endfunction

		// byte goes into the low bits, then 32 MSB-first shifts
		function crc_word_t fold_byte(crc_word_t c, byte_t b);
			crc_word_t v;
			v = c ^ {24'h0, b};
			for (int k = 0; k < CRC_W; k++) begin
				if (v[CRC_W-1]) begin
					v = (v << 1) ^ poly;
				end else begin
					v = v << 1;
				end
			end
			return v;
		endfunction

		// accepted cmd item: update CRC, queue pass-through and any trailer
		function void take_cmd(byte_t data, logic hdr, logic last);
			tx_item_t e;
			if (hdr) begin
				crc = init_val;
			end else begin
				crc = fold_byte(crc, data);
			end
			e.out_byte  = data;
			e.frame_end = 1'b0;
			expected_bytes.push_back(e);
			if (last) begin
				for (int i = 0; i < TRAILER_BYTES; i++) begin
					e.out_byte  = crc[8*i +: 8];
					e.frame_end = (i == TRAILER_BYTES - 1);
					expected_bytes.push_back(e);
				end
			end
		endfunction

		// accepted tx item against the oldest expectation
		function void check_tx(byte_t got_byte, logic got_end);
			tx_item_t e;
			if (expected_bytes.size() == 0) begin
				$display("%0t: tx item with nothing pending: expected none, actual byte %h end %b",
					$time, got_byte, got_end);
				mismatches++;
				return;
			end
			e = expected_bytes.pop_front();
			if (got_byte !== e.out_byte) begin
				$display("%0t: out_byte: expected %h, actual %h", $time, e.out_byte, got_byte);
				mismatches++;
			end
			if (got_end !== e.frame_end) begin
				$display("%0t: frame_end: expected %b, actual %b", $time, e.frame_end, got_end);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	crce_cmd_if cmd_ch ();
	crce_tx_if  tx_ch ();
	crce_cfg_if cfg_ch ();

	crc_framed_command_encoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	crc_frame_predictor pred = new();

	int         items_sent;
	int         burst_left;
	bit         gaps_on;
	int         hold_seq;
	int         hold_seen;
	int         hold_left;
	logic [7:0] stall_phase;
	int         idle_cycles;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: long hold-off on request, otherwise a rotating stall pattern
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			tx_ch.ready <= 1'b0;
		end else begin
			stall_phase++;
			case (stall_phase[7:6])
				2'd0: tx_ch.ready <= 1'b1;
				2'd1: tx_ch.ready <= ($urandom_range(0, 1) == 1);
				2'd2: tx_ch.ready <= (stall_phase % 3 != 0);
				default: tx_ch.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// tx monitor
	always @(posedge clk) begin
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			pred.check_tx(tx_ch.out_byte, tx_ch.frame_end);
		end
	end

	// watchdog: cycles with no item moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (tx_ch.valid && tx_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("crc_framed_command_encoder: mismatch");
					$finish;
				end
			end
		end
	end

	// offer one cmd item at a falling edge, return at the falling edge after acceptance
	task automatic send_item(input byte_t data, input logic hdr, input logic last);
		cmd_ch.valid     <= 1'b1;
		cmd_ch.data_byte <= data;
		cmd_ch.is_header <= hdr;
		cmd_ch.is_last   <= last;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pred.take_cmd(data, hdr, last);
		items_sent++;
		@(negedge clk);
	endtask

	// burst/gap pacing of the sender
	task automatic pace();
		if (!gaps_on) return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// stop offering and wait until every expected byte has come out
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pred.pending() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// register write; call only with the block drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input crc_word_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		pred.apply_cfg(idx, val);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// optional header, then body_len random bytes, the final one marked last
	task automatic send_frame(input bit with_header, input int body_len);
		if (with_header) begin
			send_item(byte_t'($urandom_range(0, 255)), 1'b1, body_len == 0);
			pace();
		end
		for (int i = 1; i <= body_len; i++) begin
			send_item(byte_t'($urandom_range(0, 255)), 1'b0, i == body_len);
			pace();
		end
	endtask

	// mostly well-formed frames, some headerless bodies and loose noise items
	task automatic run_phase(input int n_items);
		int target;
		int pick;
		target = items_sent + n_items;
		while (items_sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_item(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				pace();
			end else if (pick == 1) begin
				send_frame(1'b0, $urandom_range(1, 3));
			end else if (pick == 2) begin
				send_frame(1'b1, $urandom_range(16, 24));
			end else begin
				send_frame(1'b1, $urandom_range(0, 6));
			end
		end
	endtask

	// stimulus
	initial begin
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.data_byte = '0;
		cmd_ch.is_header = 1'b0;
		cmd_ch.is_last   = 1'b0;
		tx_ch.ready      = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		items_sent       = 0;
		burst_left       = 0;
		gaps_on          = 1'b0;
		hold_seq         = 0;
		hold_seen        = 0;
		hold_left        = 0;
		stall_phase      = '0;
		idle_cycles      = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes under reset settings
		send_item(8'h04, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b0);
		send_item(8'h01, 1'b0, 1'b1);
		// header that is also last: empty body, trailer is the initial value
		send_item(8'hFF, 1'b1, 1'b1);
		// body with no header continues from the previous CRC
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
		// one-byte body
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h7F, 1'b0, 1'b1);
		// two headers in a row, second one wins
		send_item(8'h10, 1'b1, 1'b0);
		send_item(8'h11, 1'b1, 1'b0);
		send_item(8'h22, 1'b0, 1'b1);
		drain();
		// new initial value takes effect only at the next header
		write_reg(REG_INIT, 32'h12345678);
		send_item(8'h3C, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		drain();
		// new polynomial applies to the very next body byte
		write_reg(REG_POLY, 32'h1EDC6F41);
		send_item(8'hC3, 1'b0, 1'b1);
		drain();

		// random phases over several register settings
		for (int phase = 0; phase < 8; phase++) begin
			gaps_on = (phase != 1) && (phase != 6);
			case (phase)
				0: begin
					write_reg(REG_POLY, 32'h0);
					write_reg(REG_INIT, 32'h0);
				end
				1: begin
					write_reg(REG_POLY, 32'hFFFFFFFF);
					write_reg(REG_INIT, 32'hFFFFFFFF);
				end
				2: begin
					write_reg(REG_POLY, $urandom());
					write_reg(REG_INIT, $urandom());
				end
				3: begin
					write_reg(REG_POLY, CRC_POLY_RST);
					write_reg(REG_INIT, $urandom());
					write_reg(REG_UNMAPPED_LO, $urandom());
				end
				4: begin
					write_reg(REG_POLY, $urandom());
					write_reg(REG_INIT, 32'h0);
				end
				5: begin
					write_reg(REG_UNMAPPED_HI, 32'hFFFFFFFF);
					write_reg(REG_POLY, $urandom());
				end
				6: begin
					write_reg(REG_POLY, CRC_POLY_RST);
					write_reg(REG_INIT, CRC_INIT_RST);
				end
				default: begin
					write_reg(REG_POLY, $urandom());
					write_reg(REG_INIT, $urandom());
				end
			endcase
			if (phase == 2) begin
				// receiver holds off while a long frame keeps coming
				hold_seq++;
				gaps_on = 1'b0;
				send_frame(1'b1, 24);
				gaps_on = 1'b1;
			end
			run_phase(PHASE_ITEMS);
			drain();
		end

		repeat (10) @(posedge clk);
		if (pred.mismatches == 0 && pred.pending() == 0) begin
			$display("crc_framed_command_encoder: match");
		end else begin
			$display("crc_framed_command_encoder: mismatch");
		end
		$finish;
	end

endmodule
